// File: sv/ppo_pkg.sv
package ppo_pkg;

  // Largest entry count any configuration can select
  localparam int unsigned SizeCap = 16;

  localparam int unsigned ValueW = 5;
  localparam int unsigned IterW  = 16;

  typedef enum logic [1:0] {
    REQ_WR_PERM = 2'd0,
    REQ_WR_VEC  = 2'd1,
    REQ_APPLY   = 2'd2,
    REQ_ORDER   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_ACTIVE_SIZE = 2'd0,
    CFG_MAX_ITER    = 2'd1
  } cfg_idx_e;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INIT_RD = 9'b000000010,
    S_INIT_WR = 9'b000000100,
    S_CMP_A   = 9'b000001000,
    S_CMP_B   = 9'b000010000,
    S_CMP_C   = 9'b000100000,
    S_EMIT_RD = 9'b001000000,
    S_EMIT_WR = 9'b010000000,
    S_RESULT  = 9'b100000000
  } state_e;

  // Clamp a stored or written value into 1..n
  function automatic logic [ValueW-1:0] clampv(input logic [ValueW-1:0] v,
                                                input logic [ValueW-1:0] n);
    logic [ValueW-1:0] r;
    r = v;
    if (r == '0) r = ValueW'(1);
    if (r > n) r = n;
    return r;
  endfunction

endpackage

// File: sv/ppo_ram.sv
module ppo_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/permutation_power_and_order.sv
// Permutation power and order engine.
// Input channel (in_valid_i / in_stall_o) takes one request word: write a
// permutation entry, write a vector entry, apply the permutation count times
// to the vector, or search the order of the permutation. Results leave on the
// output channel (out_valid_o / out_stall_i) through one output register, so a
// finished word may wait there while the engine already takes the next request.
// Operations, with n the effective size:
//   writes give no result;
//   apply composes the permutation count times over all n entries, then
//   emits n words, the last one marked with last_o;
//   order copies the permutation to the work copy, then composes once per
//   try (up to max_iterations), then gives one word with the order
//   or status 1 when no order was found.
// The rate is set by the single read port of the permutation RAM and the
// vector/work RAM: each entry needs a read of both, a dependent permutation
// read and a write-back.
// A stalled output word holds; emitting pauses until the word is taken.
// Reset clears control state and loads active_size 13 and max_iterations 4095;
// the RAM contents are undefined until written.
module permutation_power_and_order #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  position_i,
  input  logic [4:0]  value_i,
  input  logic [15:0] count_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [3:0]  position_res_o,
  output logic [4:0]  value_res_o,
  output logic [15:0] order_o,
  output logic        last_o
);

  localparam int unsigned AddrW = $clog2(MAX_SIZE);
  localparam int unsigned VW    = ppo_pkg::ValueW;
  localparam int unsigned IW    = ppo_pkg::IterW;
  localparam int unsigned Cap   = (MAX_SIZE < ppo_pkg::SizeCap) ? MAX_SIZE
                                                                : ppo_pkg::SizeCap;
  localparam logic [VW-1:0] CapN = VW'(Cap);

  ppo_pkg::state_e state_q, state_d;

  logic [VW-1:0]    active_size_q;
  logic [IW-1:0]    max_iter_q;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic             bank_q, bank_d;   // 0 vector, 1 work copy
  logic             mism_q, mism_d;
  logic             fail_q, fail_d;
  logic [VW-1:0]    pcl_q, pcl_d;

  logic             out_valid_q;
  logic             out_load;
  logic             out_status_d, out_last_d;
  logic [3:0]       out_pos_d;
  logic [VW-1:0]    out_val_d;
  logic [IW-1:0]    out_order_d;
  logic             status_q, last_q;
  logic [3:0]       pos_res_q;
  logic [VW-1:0]    val_res_q;
  logic [IW-1:0]    order_q;

  logic [VW-1:0]    n_eff;
  logic [IW-1:0]    iter_cap;
  logic             idx_last;
  logic             in_acc;
  logic             out_free;
  logic             pos_ok;
  logic [AddrW-1:0] pos_addr;

  logic             perm_we;
  logic [AddrW-1:0] perm_waddr, perm_raddr;
  logic [VW-1:0]    perm_wdata, perm_rdata;
  logic             data_we;
  logic [AddrW:0]   data_waddr, data_raddr;
  logic [VW-1:0]    data_wdata, data_rdata;

  logic [VW-1:0]    perm_cl, data_cl;
  logic             pass_match;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= VW'(13);
      max_iter_q    <= IW'(4095);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppo_pkg::CFG_ACTIVE_SIZE: active_size_q <= cfg_wdata_i[VW-1:0];
        ppo_pkg::CFG_MAX_ITER:    max_iter_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = active_size_q;
    if (n_eff == '0) n_eff = VW'(1);
    if (n_eff > CapN) n_eff = CapN;
  end

  assign iter_cap = (max_iter_q == '0) ? IW'(1) : max_iter_q;
  assign idx_last = (32'(idx_q) == 32'(n_eff) - 32'd1);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ppo_pkg::S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign pos_ok   = (32'(position_i) < MAX_SIZE);
  assign pos_addr = AddrW'(position_i);

  assign perm_cl    = ppo_pkg::clampv(perm_rdata, n_eff);
  assign data_cl    = ppo_pkg::clampv(data_rdata, n_eff);
  assign pass_match = !mism_q && (perm_cl == pcl_q);

  // RAM ports
  always_comb begin
    perm_we    = 1'b0;
    perm_waddr = pos_addr;
    perm_wdata = ppo_pkg::clampv(value_i, n_eff);
    perm_raddr = idx_q;
    data_we    = 1'b0;
    data_waddr = {bank_q, idx_q};
    data_wdata = perm_cl;
    data_raddr = {bank_q, idx_q};

    unique case (state_q)
      ppo_pkg::S_IDLE: begin
        if (in_acc && pos_ok) begin
          perm_we    = (req_type_i == ppo_pkg::REQ_WR_PERM);
          data_we    = (req_type_i == ppo_pkg::REQ_WR_VEC);
          data_waddr = {1'b0, pos_addr};
          data_wdata = ppo_pkg::clampv(value_i, n_eff);
        end
      end
      ppo_pkg::S_INIT_WR: begin
        data_we    = 1'b1;
        data_waddr = {1'b1, idx_q};
      end
      ppo_pkg::S_CMP_B: begin
        perm_raddr = AddrW'(data_cl - VW'(1));
      end
      ppo_pkg::S_CMP_C: begin
        data_we = 1'b1;
      end
      ppo_pkg::S_EMIT_WR: begin
        data_we    = 1'b1;
        data_wdata = data_cl;
      end
      default: ;
    endcase
  end

  ppo_ram #(
    .Width(VW),
    .Depth(MAX_SIZE)
  ) u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (perm_we),
    .waddr_i(perm_waddr),
    .wdata_i(perm_wdata),
    .raddr_i(perm_raddr),
    .rdata_o(perm_rdata)
  );

  // Lower half holds the vector, upper half the work copy
  ppo_ram #(
    .Width(VW),
    .Depth(2 * MAX_SIZE)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .waddr_i(data_waddr),
    .wdata_i(data_wdata),
    .raddr_i(data_raddr),
    .rdata_o(data_rdata)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    bank_d       = bank_q;
    mism_d       = mism_q;
    fail_d       = fail_q;
    pcl_d        = pcl_q;
    out_load     = 1'b0;
    out_status_d = 1'b0;
    out_pos_d    = '0;
    out_val_d    = '0;
    out_order_d  = '0;
    out_last_d   = 1'b1;

    unique case (state_q)
      ppo_pkg::S_IDLE: begin
        if (in_acc) begin
          idx_d  = '0;
          mism_d = 1'b0;
          unique case (req_type_i)
            ppo_pkg::REQ_APPLY: begin
              bank_d  = 1'b0;
              cnt_d   = count_i;
              state_d = (count_i == '0) ? ppo_pkg::S_EMIT_RD : ppo_pkg::S_CMP_A;
            end
            ppo_pkg::REQ_ORDER: begin
              bank_d  = 1'b1;
              cnt_d   = IW'(1);
              state_d = ppo_pkg::S_INIT_RD;
            end
            default: ;
          endcase
        end
      end
      ppo_pkg::S_INIT_RD: begin
        state_d = ppo_pkg::S_INIT_WR;
      end
      ppo_pkg::S_INIT_WR: begin
        if (idx_last) begin
          idx_d   = '0;
          state_d = ppo_pkg::S_CMP_A;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ppo_pkg::S_INIT_RD;
        end
      end
      ppo_pkg::S_CMP_A: begin
        state_d = ppo_pkg::S_CMP_B;
      end
      ppo_pkg::S_CMP_B: begin
        // Hold the clamped original entry for the order check
        pcl_d   = perm_cl;
        state_d = ppo_pkg::S_CMP_C;
      end
      ppo_pkg::S_CMP_C: begin
        if (perm_cl != pcl_q) mism_d = 1'b1;
        if (!idx_last) begin
          idx_d   = idx_q + 1'b1;
          state_d = ppo_pkg::S_CMP_A;
        end else begin
          idx_d  = '0;
          mism_d = 1'b0;
          if (!bank_q) begin
            cnt_d   = cnt_q - IW'(1);
            state_d = (cnt_q == IW'(1)) ? ppo_pkg::S_EMIT_RD : ppo_pkg::S_CMP_A;
          end else if (pass_match) begin
            fail_d  = 1'b0;
            state_d = ppo_pkg::S_RESULT;
          end else if (cnt_q == iter_cap) begin
            fail_d  = 1'b1;
            state_d = ppo_pkg::S_RESULT;
          end else begin
            cnt_d   = cnt_q + IW'(1);
            state_d = ppo_pkg::S_CMP_A;
          end
        end
      end
      ppo_pkg::S_EMIT_RD: begin
        // Read only once the output register is sure to be free
        if (out_free) state_d = ppo_pkg::S_EMIT_WR;
      end
      ppo_pkg::S_EMIT_WR: begin
        out_load   = 1'b1;
        out_pos_d  = 4'(idx_q);
        out_val_d  = data_cl;
        out_last_d = idx_last;
        if (idx_last) begin
          state_d = ppo_pkg::S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ppo_pkg::S_EMIT_RD;
        end
      end
      ppo_pkg::S_RESULT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = fail_q;
          out_order_d  = fail_q ? '0 : cnt_q;
          state_d      = ppo_pkg::S_IDLE;
        end
      end
      default: state_d = ppo_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppo_pkg::S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      bank_q      <= 1'b0;
      mism_q      <= 1'b0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      bank_q  <= bank_d;
      mism_q  <= mism_d;
      fail_q  <= fail_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pcl_q <= pcl_d;
    if (out_load) begin
      status_q  <= out_status_d;
      pos_res_q <= out_pos_d;
      val_res_q <= out_val_d;
      order_q   <= out_order_d;
      last_q    <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign position_res_o = pos_res_q;
  assign value_res_o    = val_res_q;
  assign order_o        = order_q;
  assign last_o         = last_q;

endmodule
